### rtl/core/sgsb_pkg.sv
package sgsb_pkg;

  // Default geometry
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_MEMORY_DEPTH   = 2048;

  // Band base saturates here; at or beyond the default screen memory depth
  localparam logic [12:0] BASE_MAX = 13'h1FFF;

  // At most this many cells of a band can carry a nonzero mask
  localparam logic [2:0] MAX_BAND_CELLS = 3'd4;

  // y / 3 as (y * 171) >> 9, exact for every 8-bit y
  localparam logic [15:0] DIV3_RECIP = 16'd171;
  localparam int          DIV3_SHIFT = 9;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BAND   = 2'd1,
    OP_HWRITE = 2'd2,
    OP_HREAD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CELL,
    ST_RMW,
    ST_HWR,
    ST_HRD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  x_position;
    logic [7:0]  y_position;
    logic [7:0]  width_pixels;
    logic [7:0]  row_top_bits;
    logic [7:0]  row_middle_bits;
    logic [7:0]  row_bottom_bits;
    logic [10:0] cell_address;
    logic [7:0]  cell_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] cells_written;
    logic       dropped;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic quot_load;
    logic start_set;
    logic mem_rd_cell;
    logic mem_wr_cell;
    logic next_cell;
    logic drop_set;
    logic base_step;
    logic host_wr;
    logic host_rd;
    logic capture_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cell_active;
    logic       mask_nz;
    logic       addr_ok;
    logic       host_ok;
    logic       out_free;
  } status_t;

  // Mosaic mask of one cell: bit0 top-left ... bit5 bottom-right
  function automatic logic [5:0] cell_mask(input logic [7:0] r0, input logic [7:0] r1,
                                           input logic [7:0] r2, input logic [1:0] idx);
    logic [2:0] hi;
    logic [2:0] lo;
    hi = {~idx, 1'b1};
    lo = {~idx, 1'b0};
    return {r2[lo], r2[hi], r1[lo], r1[hi], r0[lo], r0[hi]};
  endfunction

  // 0x20..0x3F and 0x60..0x7F are mosaic characters; all else decodes to 0
  function automatic logic [5:0] char_to_mask(input logic [7:0] c);
    logic [5:0] m;
    case (c[7:5])
      3'b001:  m = {1'b0, c[4:0]};
      3'b011:  m = {1'b1, c[4:0]};
      default: m = 6'd0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] mask_to_char(input logic [5:0] m);
    return {1'b0, m[5], 1'b1, m[4:0]};
  endfunction

endpackage

### rtl/core/sgsb_ram.sv
module sgsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sgsb_ctrl.sv
module sgsb_ctrl import sgsb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (status_i.op)
            OP_START:  state_d = ST_DIV;
            OP_BAND:   state_d = ST_CELL;
            OP_HWRITE: state_d = ST_HWR;
            default:   state_d = ST_HRD;
          endcase
        end
      end
      ST_DIV:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_CELL: begin
        if (!status_i.cell_active) begin
          state_d = ST_DONE;
        end else if (status_i.mask_nz && status_i.addr_ok) begin
          state_d = ST_RMW;
        end
      end
      ST_RMW:  state_d = ST_CELL;
      ST_HWR:  state_d = ST_DONE;
      ST_HRD:  state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_DIV:  cmd_o.quot_load = 1'b1;
      ST_MUL:  cmd_o.start_set = 1'b1;
      ST_CELL: begin
        if (!status_i.cell_active) begin
          cmd_o.base_step = 1'b1;
        end else if (!status_i.mask_nz) begin
          cmd_o.next_cell = 1'b1;
        end else if (!status_i.addr_ok) begin
          cmd_o.drop_set  = 1'b1;
          cmd_o.next_cell = 1'b1;
        end else begin
          cmd_o.mem_rd_cell = 1'b1;
        end
      end
      ST_RMW: begin
        cmd_o.mem_wr_cell = 1'b1;
        cmd_o.next_cell   = 1'b1;
      end
      ST_HWR:  cmd_o.host_wr = status_i.host_ok;
      ST_HRD:  cmd_o.host_rd = status_i.host_ok;
      ST_DONE: begin
        cmd_o.capture_rd = 1'b1;
        cmd_o.finish     = status_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/core/sgsb_datapath.sv
module sgsb_datapath import sgsb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int MEMORY_DEPTH   = DEF_MEMORY_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int          AW      = $clog2(MEMORY_DEPTH);
  localparam logic [13:0] DEPTH_W = 14'(MEMORY_DEPTH);
  localparam logic [7:0]  COLS_W  = 8'(SCREEN_COLUMNS);

  in_item_t    item_q;
  logic [6:0]  quot_q;
  logic [12:0] base_q, base_d;
  logic [6:0]  col_q;
  logic [6:0]  width_q;
  logic [2:0]  cc_q;
  logic [2:0]  cnt_q;
  logic        drop_q;
  logic        rd_pend_q;
  logic [7:0]  rd_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [15:0] y_scaled;
  logic [14:0] start_prod;
  logic [13:0] base_sum;
  logic [2:0]  band_cells;
  logic [5:0]  mask;
  logic [13:0] cell_addr;
  logic [13:0] host_addr;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [7:0]  rd_final;

  assign y_scaled   = 16'(item_q.y_position) * DIV3_RECIP;
  assign start_prod = 15'(quot_q) * 15'(COLS_W);
  assign base_sum   = 14'(base_q) + 14'(COLS_W);

  always_comb begin
    if (cmd_i.start_set) begin
      base_d = (start_prod > 15'(BASE_MAX)) ? BASE_MAX : start_prod[12:0];
    end else begin
      base_d = (base_sum > 14'(BASE_MAX)) ? BASE_MAX : base_sum[12:0];
    end
  end

  assign band_cells = (width_q > 7'(MAX_BAND_CELLS)) ? MAX_BAND_CELLS : width_q[2:0];
  assign mask       = cell_mask(item_q.row_top_bits, item_q.row_middle_bits,
                                item_q.row_bottom_bits, cc_q[1:0]);
  assign cell_addr  = 14'(base_q) + 14'(col_q) + 14'(cc_q[1:0]);
  assign host_addr  = 14'(item_q.cell_address);

  // The operation is needed before the item register loads
  assign status_o.op          = cmd_i.load_item ? in_item_i.operation : item_q.operation;
  assign status_o.cell_active = cc_q < band_cells;
  assign status_o.mask_nz     = mask != 6'd0;
  assign status_o.addr_ok     = cell_addr < DEPTH_W;
  assign status_o.host_ok     = host_addr < DEPTH_W;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  // Fresh read data on the first staging cycle, the held copy after that
  assign rd_final = rd_pend_q ? ram_rdata : rd_q;

  // Screen memory port
  always_comb begin
    ram_we    = cmd_i.mem_wr_cell || cmd_i.host_wr;
    ram_wdata = cmd_i.host_wr ? item_q.cell_data
                              : mask_to_char(char_to_mask(ram_rdata) | mask);
    if (cmd_i.host_wr || cmd_i.host_rd) begin
      ram_addr = host_addr[AW-1:0];
    end else begin
      ram_addr = cell_addr[AW-1:0];
    end
  end

  sgsb_ram #(
    .WIDTH (8),
    .DEPTH (MEMORY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
    if (cmd_i.quot_load) begin
      quot_q <= 7'(y_scaled >> DIV3_SHIFT);
    end
    if (cmd_i.finish) begin
      out_q <= '{read_data: rd_final, cells_written: cnt_q, dropped: drop_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      col_q       <= '0;
      width_q     <= '0;
      cc_q        <= '0;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start_set) begin
        col_q   <= item_q.x_position[7:1];
        width_q <= item_q.width_pixels[7:1];
      end
      if (cmd_i.start_set || cmd_i.base_step) begin
        base_q <= base_d;
      end
      if (cmd_i.load_item) begin
        cc_q      <= '0;
        cnt_q     <= '0;
        drop_q    <= 1'b0;
        rd_pend_q <= 1'b0;
        rd_q      <= '0;
      end else begin
        if (cmd_i.next_cell) begin
          cc_q <= cc_q + 3'd1;
        end
        if (cmd_i.mem_wr_cell) begin
          cnt_q <= cnt_q + 3'd1;
        end
        if (cmd_i.drop_set) begin
          drop_q <= 1'b1;
        end
        if (cmd_i.host_rd) begin
          rd_pend_q <= 1'b1;
        end
        // Read data lands in the cycle after the host read; take it once
        if (cmd_i.capture_rd && rd_pend_q) begin
          rd_q      <= ram_rdata;
          rd_pend_q <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/core/semigraphics_sprite_or_blit_top.sv
// From accepting a request to result valid: start divides, multiplies, then stages the
// result; host write and host read access the memory, then stage; band visits each cell,
// a skipped or dropped cell is passed over, a written cell is read then written for the
// read-modify-write through the single screen memory port, then takes the base step and stages.
// Throughput: one request at a time; the next is taken the cycle after the result is staged.
// Reset clears sprite position, width, band base and handshake state, not screen memory.
module semigraphics_sprite_or_blit_top import sgsb_pkg::*; #(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int MEMORY_DEPTH   = DEF_MEMORY_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t    cmd;
  status_t status;

  // Sequence each request: decode, start divide and multiply, per-cell read-modify-write, host access, result staging
  sgsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold sprite state, screen memory, mask and address math, and the result register
  sgsb_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .MEMORY_DEPTH   (MEMORY_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
